/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define EPCM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define EPCM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/epcm_pkg.sv */
// Package for the EMA peak/change monitor: sizes, register codes, reset values, types.
// No dependencies; compile first.
package epcm_pkg;

  // Sample and fixed point sizes
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 24;
  localparam int ALPHA_FRAC    = 24;
  localparam int ALPHA_W       = ALPHA_FRAC + 1;
  localparam int AVG_W         = SAMPLE_BITS + FRACTION_BITS + 1;
  localparam int MAG_W         = SAMPLE_BITS + FRACTION_BITS;
  localparam int HI_W          = MAG_W - ALPHA_FRAC;
  localparam int THRESH_W      = 16;
  localparam int MODE_W        = 2;
  localparam int FWD_W         = 4;
  localparam int CMP_W         = (SAMPLE_BITS + 1 > THRESH_W) ? SAMPLE_BITS + 1 : THRESH_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ALPHA_W;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FAST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MEDIUM     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SLOW       = 3'd4;

  // Display modes; the unused code behaves as "other"
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHART = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

  // Reset values of the registers
  localparam logic [MODE_W-1:0]   RST_DISPLAY_MODE = MODE_OTHER;
  localparam logic [THRESH_W-1:0] RST_THRESHOLD    = 16'd5;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA_FAST   = 25'd5033165;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA_MEDIUM = 25'd33554;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA_SLOW   = 25'd554;

  // Unity weight and rounding constants
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC{1'b0}}};
  localparam logic [AVG_W-1:0]   AVG_HALF  =
    {{(AVG_W - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

  // Bit positions of the forwarded event bits
  localparam int FWD_MODE      = 0;
  localparam int FWD_HIGHLIGHT = 1;
  localparam int FWD_FORCE     = 2;
  localparam int FWD_CHANGED   = 3;

  // One registered input item
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] current_a;
    logic signed [SAMPLE_BITS-1:0] current_b;
    logic        [SAMPLE_BITS-1:0] voltage_a;
    logic        [SAMPLE_BITS-1:0] voltage_b;
    logic                          force_update;
    logic                          mode_change;
    logic                          highlight_change;
  } sample_t;

  // Averaging weights
  typedef struct packed {
    logic [ALPHA_W-1:0] fast;
    logic [ALPHA_W-1:0] mid;
    logic [ALPHA_W-1:0] slow;
  } alpha_set_t;

  // Change decision for one item
  typedef struct packed {
    logic changed;
    logic publish;
  } pub_status_t;

endpackage

/* rtl/core/epcm_if.sv */
// Channel interfaces of the EMA peak/change monitor: sample in, result out, config write.
// Depends on epcm_pkg.
interface epcm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] current_a;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] current_b;
  logic        [epcm_pkg::SAMPLE_BITS-1:0] voltage_a;
  logic        [epcm_pkg::SAMPLE_BITS-1:0] voltage_b;
  logic                                   force_update;
  logic                                   mode_change;
  logic                                   highlight_change;

  modport source (output valid, current_a, current_b, voltage_a, voltage_b,
                  force_update, mode_change, highlight_change, input ready);
  modport sink   (input valid, current_a, current_b, voltage_a, voltage_b,
                  force_update, mode_change, highlight_change, output ready);
endinterface

interface epcm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   published;
  logic        [epcm_pkg::FWD_W-1:0]       forward_bits;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] fast_avg_a;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] fast_avg_b;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] medium_avg_a;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] medium_avg_b;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] slow_avg_a;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] slow_avg_b;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] peak_a;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] peak_b;

  modport source (output valid, published, forward_bits, fast_avg_a, fast_avg_b,
                  medium_avg_a, medium_avg_b, slow_avg_a, slow_avg_b, peak_a, peak_b,
                  input ready);
  modport sink   (input valid, published, forward_bits, fast_avg_a, fast_avg_b,
                  medium_avg_a, medium_avg_b, slow_avg_a, slow_avg_b, peak_a, peak_b,
                  output ready);
endinterface

interface epcm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [epcm_pkg::CFG_IDX_W-1:0]    index;
  logic [epcm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/epcm_ema_unit.sv */
// One exponential average step: avg + alpha * (x - avg), rounded half away from zero.
// Depends on epcm_pkg.
module epcm_ema_unit (
  input  logic signed [epcm_pkg::AVG_W-1:0]       avg,
  input  logic signed [epcm_pkg::SAMPLE_BITS-1:0] x,
  input  logic        [epcm_pkg::ALPHA_W-1:0]     alpha,
  output logic        [epcm_pkg::AVG_W-1:0]       avg_nxt
);

  localparam int DIFF_W = epcm_pkg::AVG_W + 1;
  localparam int PH_W   = epcm_pkg::ALPHA_W + epcm_pkg::HI_W;
  localparam int PL_W   = epcm_pkg::ALPHA_W + epcm_pkg::ALPHA_FRAC;
  localparam int LQ_W   = PL_W + 1 - epcm_pkg::ALPHA_FRAC;
  localparam logic [PL_W:0] LO_HALF =
    {{(PL_W + 1 - epcm_pkg::ALPHA_FRAC){1'b0}}, 1'b1, {(epcm_pkg::ALPHA_FRAC - 1){1'b0}}};

  logic signed [DIFF_W-1:0]             target_w;
  logic signed [DIFF_W-1:0]             avg_w;
  logic signed [DIFF_W-1:0]             diff_w;
  logic                                 neg;
  logic        [DIFF_W-1:0]             mag_w;
  logic        [epcm_pkg::MAG_W-1:0]    mag;
  logic        [epcm_pkg::ALPHA_W-1:0]  alpha_c;
  logic        [epcm_pkg::HI_W-1:0]     hi;
  logic        [epcm_pkg::ALPHA_FRAC-1:0] lo;
  logic        [PH_W-1:0]               p_hi;
  logic        [PL_W-1:0]               p_lo;
  logic        [PL_W:0]                 p_lo_rnd;
  logic        [LQ_W-1:0]               lo_q;
  logic        [epcm_pkg::AVG_W-1:0]    d;

  // Difference to the target in the average's fixed point
  assign target_w = DIFF_W'(signed'({x, {epcm_pkg::FRACTION_BITS{1'b0}}}));
  assign avg_w    = DIFF_W'(avg);
  assign diff_w   = target_w - avg_w;
  assign neg      = diff_w[DIFF_W-1];
  assign mag_w    = neg ? (~diff_w + 1'b1) : diff_w;
  assign mag      = mag_w[epcm_pkg::MAG_W-1:0];

  // Clamp the weight to one
  assign alpha_c = (alpha > epcm_pkg::ALPHA_ONE) ? epcm_pkg::ALPHA_ONE : alpha;

  // Split the magnitude so each product stays narrow
  assign hi       = mag[epcm_pkg::MAG_W-1:epcm_pkg::ALPHA_FRAC];
  assign lo       = mag[epcm_pkg::ALPHA_FRAC-1:0];
  assign p_hi     = PH_W'(alpha_c) * PH_W'(hi);
  assign p_lo     = PL_W'(alpha_c) * PL_W'(lo);
  assign p_lo_rnd = {1'b0, p_lo} + LO_HALF;
  assign lo_q     = p_lo_rnd[PL_W:epcm_pkg::ALPHA_FRAC];
  assign d        = epcm_pkg::AVG_W'(p_hi) + epcm_pkg::AVG_W'(lo_q);

  // Apply the step with its sign
  assign avg_nxt = neg ? (avg - d) : (avg + d);

endmodule

/* rtl/core/epcm_channel.sv */
// Per-channel averaging state: fast, medium and slow averages plus the running peak.
// Depends on epcm_pkg and epcm_ema_unit.
module epcm_channel (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  upd,
  input  logic signed [epcm_pkg::SAMPLE_BITS-1:0] cur,
  input  epcm_pkg::alpha_set_t                  alphas,
  output logic signed [epcm_pkg::SAMPLE_BITS-1:0] fast_avg,
  output logic signed [epcm_pkg::SAMPLE_BITS-1:0] medium_avg,
  output logic signed [epcm_pkg::SAMPLE_BITS-1:0] slow_avg,
  output logic signed [epcm_pkg::SAMPLE_BITS-1:0] peak
);

  logic signed [epcm_pkg::AVG_W-1:0]       fast_r, medium_r, slow_r;
  logic        [epcm_pkg::AVG_W-1:0]       fast_nxt, medium_nxt, slow_nxt;
  logic signed [epcm_pkg::SAMPLE_BITS-1:0] peak_r, peak_nxt;

  // Round half up to whole LSB units
  function automatic logic [epcm_pkg::SAMPLE_BITS-1:0] round_avg(
    input logic [epcm_pkg::AVG_W-1:0] a
  );
    logic [epcm_pkg::AVG_W-1:0] s;
    s = a + epcm_pkg::AVG_HALF;
    return s[epcm_pkg::FRACTION_BITS + epcm_pkg::SAMPLE_BITS - 1:epcm_pkg::FRACTION_BITS];
  endfunction

  epcm_ema_unit u_fast (
    .avg(fast_r), .x(cur), .alpha(alphas.fast), .avg_nxt(fast_nxt)
  );
  epcm_ema_unit u_medium (
    .avg(medium_r), .x(cur), .alpha(alphas.mid), .avg_nxt(medium_nxt)
  );
  epcm_ema_unit u_slow (
    .avg(slow_r), .x(cur), .alpha(alphas.slow), .avg_nxt(slow_nxt)
  );

  // Raise the peak on a larger current
  assign peak_nxt = (cur > peak_r) ? cur : peak_r;

  // Advance the state on each counted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r   <= '0;
      medium_r <= '0;
      slow_r   <= '0;
      peak_r   <= '0;
    end else if (upd) begin
      fast_r   <= fast_nxt;
      medium_r <= medium_nxt;
      slow_r   <= slow_nxt;
      peak_r   <= peak_nxt;
    end
  end

  assign fast_avg   = round_avg(fast_r);
  assign medium_avg = round_avg(medium_r);
  assign slow_avg   = round_avg(slow_r);
  assign peak       = peak_r;

endmodule

/* rtl/core/epcm_publish.sv */
// Change detection against the last published sample, and storage of that sample.
// Depends on epcm_pkg.
module epcm_publish (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  epcm_pkg::sample_t                 smp,
  input  logic [epcm_pkg::MODE_W-1:0]       mode,
  input  logic [epcm_pkg::THRESH_W-1:0]     threshold,
  output epcm_pkg::pub_status_t             status
);

  localparam int S = epcm_pkg::SAMPLE_BITS;

  logic signed [S-1:0] last_cur_a_r, last_cur_b_r;
  logic        [S-1:0] last_volt_a_r, last_volt_b_r;
  logic                mode_forces;
  logic                moved;

  // Absolute difference of two signed samples above the threshold
  function automatic logic differs_s(
    input logic signed [S-1:0] a,
    input logic signed [S-1:0] b,
    input logic [epcm_pkg::THRESH_W-1:0] thr
  );
    logic signed [S:0] dv;
    logic        [S:0] mv;
    dv = {a[S-1], a} - {b[S-1], b};
    mv = dv[S] ? (~dv + 1'b1) : dv;
    return epcm_pkg::CMP_W'(mv) > epcm_pkg::CMP_W'(thr);
  endfunction

  // Same for unsigned samples
  function automatic logic differs_u(
    input logic [S-1:0] a,
    input logic [S-1:0] b,
    input logic [epcm_pkg::THRESH_W-1:0] thr
  );
    logic signed [S:0] dv;
    logic        [S:0] mv;
    dv = {1'b0, a} - {1'b0, b};
    mv = dv[S] ? (~dv + 1'b1) : dv;
    return epcm_pkg::CMP_W'(mv) > epcm_pkg::CMP_W'(thr);
  endfunction

  // Decide changed and publish
  always_comb begin
    mode_forces = (mode == epcm_pkg::MODE_CHART) || (mode == epcm_pkg::MODE_COUNT);
    moved = differs_s(smp.current_a, last_cur_a_r, threshold) ||
            differs_s(smp.current_b, last_cur_b_r, threshold) ||
            differs_u(smp.voltage_a, last_volt_a_r, threshold) ||
            differs_u(smp.voltage_b, last_volt_b_r, threshold);
    status.changed = smp.force_update || mode_forces || moved;
    status.publish = status.changed || smp.mode_change || smp.highlight_change;
  end

  // Hold the published sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cur_a_r  <= '0;
      last_cur_b_r  <= '0;
      last_volt_a_r <= '0;
      last_volt_b_r <= '0;
    end else if (en && status.publish) begin
      last_cur_a_r  <= smp.current_a;
      last_cur_b_r  <= smp.current_b;
      last_volt_a_r <= smp.voltage_a;
      last_volt_b_r <= smp.voltage_b;
    end
  end

endmodule

/* rtl/core/ema_peak_change_monitor.sv */
// Top level of the two-channel EMA, peak and change monitor.
// Depends on epcm_pkg, epcm_if, epcm_channel, epcm_publish.
//
// Usage:
//   in_if  carries one sample per transfer: two currents, two voltages and
//          three event flags. out_if returns exactly one result per sample:
//          publish flag, forwarded event bits, six rounded averages, two peaks.
//   cfg_if writes one register per transfer (index 0 mode, 1 threshold,
//          2..4 alphas); it is always ready. Write it only while no sample is
//          in flight; unknown indexes are dropped.
//   Path:  a sample passes two registers on its way to out_if: the input
//          stage, then the result stage.
//   Throughput: one sample per cycle unless out_if.ready stalls; the
//          averaging recurrence for all six averages is resolved
//          combinationally between the input register and the state/result registers.
//   Stall: while out_if.ready is low the result holds, the input stage still
//          takes one more sample if it is empty, and then in_if.ready drops
//          until the result moves on.
//   Reset: rst_n low clears both stages, all averages, peaks and the
//          published sample, and loads the register defaults.
module ema_peak_change_monitor (
  input  logic        clk,
  input  logic        rst_n,
  epcm_in_if.sink     in_if,
  epcm_out_if.source  out_if,
  epcm_cfg_if.sink    cfg_if
);

  // Configuration registers
  logic [epcm_pkg::MODE_W-1:0]   mode_r;
  logic [epcm_pkg::THRESH_W-1:0] threshold_r;
  epcm_pkg::alpha_set_t          alphas_r;

  // Pipeline registers
  logic                        in_vld_r;
  epcm_pkg::sample_t           smp_r;
  logic                        out_vld_r;
  logic                        pub_r;
  logic [epcm_pkg::FWD_W-1:0]  fwd_r, fwd_nxt;

  logic                        adv;
  logic                        fire;
  logic                        count_upd;
  epcm_pkg::pub_status_t       status;

  // Take every config transfer
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= epcm_pkg::RST_DISPLAY_MODE;
      threshold_r    <= epcm_pkg::RST_THRESHOLD;
      alphas_r.fast   <= epcm_pkg::RST_ALPHA_FAST;
      alphas_r.mid    <= epcm_pkg::RST_ALPHA_MEDIUM;
      alphas_r.slow   <= epcm_pkg::RST_ALPHA_SLOW;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        epcm_pkg::REG_DISPLAY_MODE:     mode_r <= cfg_if.data[epcm_pkg::MODE_W-1:0];
        epcm_pkg::REG_CHANGE_THRESHOLD: threshold_r <= cfg_if.data[epcm_pkg::THRESH_W-1:0];
        epcm_pkg::REG_ALPHA_FAST:       alphas_r.fast <= cfg_if.data;
        epcm_pkg::REG_ALPHA_MEDIUM:     alphas_r.mid <= cfg_if.data;
        epcm_pkg::REG_ALPHA_SLOW:       alphas_r.slow <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Handshake: the result stage frees up when empty or taken
  assign adv         = !out_vld_r || out_if.ready;
  assign fire        = in_vld_r && adv;
  assign in_if.ready = !in_vld_r || adv;
  assign count_upd   = fire && (mode_r == epcm_pkg::MODE_COUNT);

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      smp_r.current_a        <= in_if.current_a;
      smp_r.current_b        <= in_if.current_b;
      smp_r.voltage_a        <= in_if.voltage_a;
      smp_r.voltage_b        <= in_if.voltage_b;
      smp_r.force_update     <= in_if.force_update;
      smp_r.mode_change      <= in_if.mode_change;
      smp_r.highlight_change <= in_if.highlight_change;
    end
  end

  // Per-channel averaging and peak
  epcm_channel u_chan_a (
    .clk(clk), .rst_n(rst_n), .upd(count_upd), .cur(smp_r.current_a), .alphas(alphas_r),
    .fast_avg(out_if.fast_avg_a), .medium_avg(out_if.medium_avg_a),
    .slow_avg(out_if.slow_avg_a), .peak(out_if.peak_a)
  );

  epcm_channel u_chan_b (
    .clk(clk), .rst_n(rst_n), .upd(count_upd), .cur(smp_r.current_b), .alphas(alphas_r),
    .fast_avg(out_if.fast_avg_b), .medium_avg(out_if.medium_avg_b),
    .slow_avg(out_if.slow_avg_b), .peak(out_if.peak_b)
  );

  // Change detection and published sample
  epcm_publish u_publish (
    .clk(clk), .rst_n(rst_n), .en(fire), .smp(smp_r), .mode(mode_r),
    .threshold(threshold_r), .status(status)
  );

  // Assemble the forwarded event bits
  always_comb begin
    fwd_nxt = '0;
    fwd_nxt[epcm_pkg::FWD_MODE]      = smp_r.mode_change;
    fwd_nxt[epcm_pkg::FWD_HIGHLIGHT] = smp_r.highlight_change;
    fwd_nxt[epcm_pkg::FWD_FORCE]     = smp_r.force_update;
    fwd_nxt[epcm_pkg::FWD_CHANGED]   = status.changed;
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pub_r <= status.publish;
      fwd_r <= fwd_nxt;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.published    = pub_r;
  assign out_if.forward_bits = fwd_r;

endmodule

/* rtl/core/epcm_checker.sv */
// Port-level checks for the EMA peak/change monitor, bound to the top level.
// Depends on epcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module epcm_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  published,
  input logic [epcm_pkg::FWD_W-1:0]            forward_bits,
  input logic signed [epcm_pkg::SAMPLE_BITS-1:0] peak_a,
  input logic signed [epcm_pkg::SAMPLE_BITS-1:0] peak_b
);

  // No result survives reset
  `EPCM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result holds its status bits
  `EPCM_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(published) && $stable(forward_bits), "stalled result changed")

  // An unpublished sample carries no events and no change
  `EPCM_ASSERT(a_no_pub_quiet, clk, rst_n, out_valid && !published |-> forward_bits == '0, "event or change without publish")

  // Force implies change and publish; the peaks never go below zero
  `EPCM_ASSERT(a_force_peak, clk, rst_n, out_valid |-> (!forward_bits[epcm_pkg::FWD_FORCE] || (forward_bits[epcm_pkg::FWD_CHANGED] && published)) && !peak_a[epcm_pkg::SAMPLE_BITS-1] && !peak_b[epcm_pkg::SAMPLE_BITS-1], "force or peak inconsistent")

endmodule

bind ema_peak_change_monitor epcm_checker u_epcm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .published(out_if.published),
  .forward_bits(out_if.forward_bits),
  .peak_a(out_if.peak_a),
  .peak_b(out_if.peak_b)
);
